/* sv/mbrc_pkg.sv */
// ----------------------------------------------------------------------------
// mbrc_pkg
// shared widths, queue sizing and control types for the bind range coalescer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbrc_pkg;

  localparam int unsigned HANDLE_W      = 64;
  localparam int unsigned FLAGS_W       = 32;
  localparam int unsigned ADDR_BITS_DEF = 48;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  // packed range entry: handle, offset, size, memory, memory offset, flags, final
  function automatic int unsigned entry_w(input int unsigned addr_bits);
    return 2 * HANDLE_W + 3 * addr_bits + FLAGS_W + 1;
  endfunction

  typedef struct packed {
    logic wr0;
    logic wr1;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    logic space;
  } q_stat_t;

endpackage

`default_nettype wire

/* sv/mbrc_req_if.sv */
// ----------------------------------------------------------------------------
// mbrc_req_if
// bind request channel: valid/ready handshake with the request fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mbrc_req_if #(
  parameter int unsigned ADDR_BITS = mbrc_pkg::ADDR_BITS_DEF
);
  import mbrc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [HANDLE_W-1:0]  resource_handle;
  logic [ADDR_BITS-1:0] resource_offset;
  logic [ADDR_BITS-1:0] range_size;
  logic [HANDLE_W-1:0]  memory_handle;
  logic [ADDR_BITS-1:0] memory_offset;
  logic [FLAGS_W-1:0]   bind_flags;
  logic                 last_request;

  modport source (
    output valid, resource_handle, resource_offset, range_size, memory_handle,
           memory_offset, bind_flags, last_request,
    input  ready
  );

  modport sink (
    input  valid, resource_handle, resource_offset, range_size, memory_handle,
           memory_offset, bind_flags, last_request,
    output ready
  );
endinterface

`default_nettype wire

/* sv/mbrc_rng_if.sv */
// ----------------------------------------------------------------------------
// mbrc_rng_if
// coalesced range channel: valid/ready handshake with the range fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mbrc_rng_if #(
  parameter int unsigned ADDR_BITS = mbrc_pkg::ADDR_BITS_DEF
);
  import mbrc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [HANDLE_W-1:0]  out_handle;
  logic [ADDR_BITS-1:0] out_offset;
  logic [ADDR_BITS-1:0] out_size;
  logic [HANDLE_W-1:0]  out_memory;
  logic [ADDR_BITS-1:0] out_memory_offset;
  logic [FLAGS_W-1:0]   out_flags;
  logic                 new_group;
  logic                 final_range;

  modport source (
    output valid, out_handle, out_offset, out_size, out_memory, out_memory_offset,
           out_flags, new_group, final_range,
    input  ready
  );

  modport sink (
    input  valid, out_handle, out_offset, out_size, out_memory, out_memory_offset,
           out_flags, new_group, final_range,
    output ready
  );
endinterface

`default_nettype wire

/* sv/memory_bind_range_coalescer.sv */
// ----------------------------------------------------------------------------
// memory_bind_range_coalescer
// folds a sorted stream of sparse bind requests into contiguous ranges
// ----------------------------------------------------------------------------
// Takes one bind request per cycle whenever the range queue has room for two
// ranges, and delivers at most one coalesced range per cycle. A request that
// merges into the pending range produces nothing; one that breaks the range
// produces one range; a last request produces one or two (the broken range and
// the flush). The output port is the limit when a request produces two ranges.
// A range is written into the range queue when its request is taken and then
// moves into the output register once that register is free or being taken.
// The four-entry queue lets the request side keep going while the output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module memory_bind_range_coalescer #(
  parameter int unsigned ADDR_BITS = mbrc_pkg::ADDR_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mbrc_req_if.sink   req_i,
  mbrc_rng_if.source rng_o
);
  import mbrc_pkg::*;

  localparam int unsigned EW = entry_w(ADDR_BITS);

  q_wr_t         q_wr;
  q_stat_t       q_stat;
  logic [EW-1:0] e0, e1, rd_data;
  logic          pop;

  mbrc_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .q_stat_i (q_stat),
    .q_wr_o   (q_wr),
    .e0_o     (e0),
    .e1_o     (e1)
  );

  mbrc_queue #(
    .ADDR_BITS (ADDR_BITS)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_wr_i    (q_wr),
    .e0_i      (e0),
    .e1_i      (e1),
    .pop_i     (pop),
    .q_stat_o  (q_stat),
    .rd_data_o (rd_data)
  );

  mbrc_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_stat_i  (q_stat),
    .rd_data_i (rd_data),
    .pop_o     (pop),
    .rng_o     (rng_o)
  );

endmodule

`default_nettype wire

/* sv/mbrc_front.sv */
// ----------------------------------------------------------------------------
// mbrc_front
// accepts requests, merges them into the pending range and pushes finished
// ranges (at most two per request) into the range queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbrc_front #(
  parameter int unsigned ADDR_BITS = mbrc_pkg::ADDR_BITS_DEF
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  mbrc_req_if.sink                                       req_i,
  input  wire mbrc_pkg::q_stat_t                         q_stat_i,
  output mbrc_pkg::q_wr_t                                q_wr_o,
  output logic [mbrc_pkg::entry_w(ADDR_BITS)-1:0]        e0_o,
  output logic [mbrc_pkg::entry_w(ADDR_BITS)-1:0]        e1_o
);
  import mbrc_pkg::*;

  localparam int unsigned A = ADDR_BITS;

  logic                pend_valid_q, pend_valid_d;
  logic [HANDLE_W-1:0] pend_handle_q, pend_handle_d;
  logic [A-1:0]        pend_offset_q, pend_offset_d;
  logic [A-1:0]        pend_size_q, pend_size_d;
  logic [HANDLE_W-1:0] pend_memory_q, pend_memory_d;
  logic [A-1:0]        pend_moff_q, pend_moff_d;
  logic [FLAGS_W-1:0]  pend_flags_q, pend_flags_d;
  // running end addresses, one bit wider so that leaving the range never matches
  logic [A:0]          pend_end_q, pend_end_d;
  logic [A:0]          pend_mend_q, pend_mend_d;

  logic       accept;
  logic       match;
  logic [A:0] size_sum;
  logic [A:0] end_merge, mend_merge, end_new, mend_new;

  assign req_i.ready = q_stat_i.space;
  assign accept      = req_i.valid && q_stat_i.space;

  assign size_sum   = {1'b0, pend_size_q} + {1'b0, req_i.range_size};
  assign end_merge  = pend_end_q + {1'b0, req_i.range_size};
  assign mend_merge = pend_mend_q + {1'b0, req_i.range_size};
  assign end_new    = {1'b0, req_i.resource_offset} + {1'b0, req_i.range_size};
  assign mend_new   = {1'b0, req_i.memory_offset} + {1'b0, req_i.range_size};

  assign match = pend_valid_q
              && (req_i.resource_handle == pend_handle_q)
              && (req_i.memory_handle == pend_memory_q)
              && (req_i.bind_flags == pend_flags_q)
              && (pend_end_q == {1'b0, req_i.resource_offset})
              && ((req_i.memory_handle == '0)
                  || (pend_mend_q == {1'b0, req_i.memory_offset}))
              && !size_sum[A];

  always_comb begin
    pend_handle_d = pend_handle_q;
    pend_offset_d = pend_offset_q;
    pend_size_d   = pend_size_q;
    pend_memory_d = pend_memory_q;
    pend_moff_d   = pend_moff_q;
    pend_flags_d  = pend_flags_q;
    pend_end_d    = pend_end_q;
    pend_mend_d   = pend_mend_q;
    pend_valid_d  = pend_valid_q;
    if (accept) begin
      if (match) begin
        pend_size_d = size_sum[A-1:0];
        pend_end_d  = end_merge;
        pend_mend_d = mend_merge;
      end else begin
        pend_handle_d = req_i.resource_handle;
        pend_offset_d = req_i.resource_offset;
        pend_size_d   = req_i.range_size;
        pend_memory_d = req_i.memory_handle;
        pend_moff_d   = req_i.memory_offset;
        pend_flags_d  = req_i.bind_flags;
        pend_end_d    = end_new;
        pend_mend_d   = mend_new;
      end
      pend_valid_d = !req_i.last_request;
    end
  end

  // old pending range, pushed out by a request that does not merge
  assign e0_o = {pend_handle_q, pend_offset_q, pend_size_q, pend_memory_q,
                 pend_moff_q, pend_flags_q, 1'b0};
  // flush of the updated pending range on the last request
  assign e1_o = {pend_handle_d, pend_offset_d, pend_size_d, pend_memory_d,
                 pend_moff_d, pend_flags_d, 1'b1};

  assign q_wr_o.wr0 = accept && !match && pend_valid_q;
  assign q_wr_o.wr1 = accept && req_i.last_request;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_handle_q <= pend_handle_d;
    pend_offset_q <= pend_offset_d;
    pend_size_q   <= pend_size_d;
    pend_memory_q <= pend_memory_d;
    pend_moff_q   <= pend_moff_d;
    pend_flags_q  <= pend_flags_d;
    pend_end_q    <= pend_end_d;
    pend_mend_q   <= pend_mend_d;
  end

endmodule

`default_nettype wire

/* sv/mbrc_queue.sv */
// ----------------------------------------------------------------------------
// mbrc_queue
// short range queue between front and back: up to two writes and one read
// per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbrc_queue #(
  parameter int unsigned ADDR_BITS = mbrc_pkg::ADDR_BITS_DEF
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire mbrc_pkg::q_wr_t                           q_wr_i,
  input  wire logic [mbrc_pkg::entry_w(ADDR_BITS)-1:0]   e0_i,
  input  wire logic [mbrc_pkg::entry_w(ADDR_BITS)-1:0]   e1_i,
  input  wire logic                                      pop_i,
  output mbrc_pkg::q_stat_t                              q_stat_o,
  output logic [mbrc_pkg::entry_w(ADDR_BITS)-1:0]        rd_data_o
);
  import mbrc_pkg::*;

  localparam int unsigned EW = entry_w(ADDR_BITS);

  logic [EW-1:0]      mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_q, wptr_d;
  logic [Q_PTR_W-1:0] rptr_q, rptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               rd;

  assign q_stat_o.valid = (cnt_q != '0);
  assign q_stat_o.space = (cnt_q <= Q_CNT_W'(Q_DEPTH - 2));
  assign rd             = pop_i && q_stat_o.valid;
  assign rd_data_o      = mem_q[rptr_q];

  assign wptr_d = wptr_q + Q_PTR_W'(q_wr_i.wr0) + Q_PTR_W'(q_wr_i.wr1);
  assign rptr_d = rptr_q + Q_PTR_W'(rd);
  assign cnt_d  = cnt_q + Q_CNT_W'(q_wr_i.wr0) + Q_CNT_W'(q_wr_i.wr1) - Q_CNT_W'(rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_wr_i.wr0) begin
      mem_q[wptr_q] <= e0_i;
    end else if (q_wr_i.wr1) begin
      mem_q[wptr_q] <= e1_i;
    end
    if (q_wr_i.wr0 && q_wr_i.wr1) begin
      mem_q[wptr_q + Q_PTR_W'(1)] <= e1_i;
    end
  end

endmodule

`default_nettype wire

/* sv/mbrc_back.sv */
// ----------------------------------------------------------------------------
// mbrc_back
// drains the range queue into the output register and tracks per-resource
// groups across emitted ranges
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbrc_back #(
  parameter int unsigned ADDR_BITS = mbrc_pkg::ADDR_BITS_DEF
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire mbrc_pkg::q_stat_t                         q_stat_i,
  input  wire logic [mbrc_pkg::entry_w(ADDR_BITS)-1:0]   rd_data_i,
  output logic                                           pop_o,
  mbrc_rng_if.source                                     rng_o
);
  import mbrc_pkg::*;

  localparam int unsigned A = ADDR_BITS;

  logic [HANDLE_W-1:0] e_handle, e_memory;
  logic [A-1:0]        e_offset, e_size, e_moff;
  logic [FLAGS_W-1:0]  e_flags;
  logic                e_final;

  logic                out_valid_q, out_valid_d;
  logic [HANDLE_W-1:0] out_handle_q, out_memory_q;
  logic [A-1:0]        out_offset_q, out_size_q, out_moff_q;
  logic [FLAGS_W-1:0]  out_flags_q;
  logic                out_group_q, out_final_q;

  logic [HANDLE_W-1:0] prev_handle_q, prev_handle_d;
  logic                grp_open_q, grp_open_d;
  logic                new_group;

  assign {e_handle, e_offset, e_size, e_memory, e_moff, e_flags, e_final} = rd_data_i;

  assign pop_o     = q_stat_i.valid && (!out_valid_q || rng_o.ready);
  assign new_group = !grp_open_q || (e_handle != prev_handle_q);

  always_comb begin
    out_valid_d   = out_valid_q;
    prev_handle_d = prev_handle_q;
    grp_open_d    = grp_open_q;
    if (pop_o) begin
      out_valid_d   = 1'b1;
      prev_handle_d = e_final ? '0 : e_handle;
      grp_open_d    = !e_final;
    end else if (rng_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      prev_handle_q <= '0;
      grp_open_q    <= 1'b0;
    end else begin
      out_valid_q   <= out_valid_d;
      prev_handle_q <= prev_handle_d;
      grp_open_q    <= grp_open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_handle_q <= e_handle;
      out_offset_q <= e_offset;
      out_size_q   <= e_size;
      out_memory_q <= e_memory;
      out_moff_q   <= e_moff;
      out_flags_q  <= e_flags;
      out_group_q  <= new_group;
      out_final_q  <= e_final;
    end
  end

  assign rng_o.valid             = out_valid_q;
  assign rng_o.out_handle        = out_handle_q;
  assign rng_o.out_offset        = out_offset_q;
  assign rng_o.out_size          = out_size_q;
  assign rng_o.out_memory        = out_memory_q;
  assign rng_o.out_memory_offset = out_moff_q;
  assign rng_o.out_flags         = out_flags_q;
  assign rng_o.new_group         = out_group_q;
  assign rng_o.final_range       = out_final_q;

endmodule

`default_nettype wire
